// ===== design/bd_pkg.sv =====
`timescale 1ns / 1ps

package bd_pkg;

  localparam int DEPTH_DEFAULT      = 256;
  localparam int DATA_WIDTH_DEFAULT = 8;
  localparam int CMD_W              = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_NOP        = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

endpackage

// ===== design/bounded_deque_top.sv =====
`timescale 1ns / 1ps

// Double-ended queue of DEPTH entries of DATA_WIDTH bits, held in a ring memory
// with two registered read ports. Every command gives exactly one result
// carrying the front and back values (zero when empty), the element count,
// empty and full flags, and an overflow flag for a push dropped on a full queue.
// A command goes from acceptance to its result thus: the accept cycle updates
// the pointers and writes the memory, ST_READ addresses the new front and back
// entries, and ST_LOAD loads the memory's registered read data into the result
// register once the output is not stalled. The input is stalled until then; a
// new command can be taken while the previous result still waits at the output.
// Popping an empty queue changes nothing. No clearing pass is needed after reset.
module bounded_deque_top #(
  parameter int DEPTH      = bd_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = bd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bd_pkg::CMD_W-1:0]      in_cmd,
  input  logic [DATA_WIDTH-1:0]         in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [DATA_WIDTH-1:0]         out_front_value,
  output logic [DATA_WIDTH-1:0]         out_back_value,
  output logic [$clog2(DEPTH+1)-1:0]    out_element_total,
  output logic                          out_is_empty,
  output logic                          out_is_full,
  output logic                          out_overflow
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  bd_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] rd_front_r, rd_back_r;

  logic                  in_acc;
  logic                  full;
  logic                  empty;
  logic                  load;
  logic [AW-1:0]         head_dec;
  logic [SW-1:0]         tail_sum;
  logic [AW-1:0]         tail_addr;
  logic [SW-1:0]         back_sum;
  logic [AW-1:0]         back_addr;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] front_r, back_r;
  logic [CW-1:0]         total_r;
  logic                  is_empty_r, is_full_r, overflow_r;

  assign in_acc = in_valid && !in_stall;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign load   = (state_r == bd_pkg::ST_LOAD) && (!out_valid_r || !out_stall);

  // ring index arithmetic
  always_comb begin
    head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
    tail_sum  = SW'(head_r) + SW'(count_r);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    tail_addr = tail_sum[AW-1:0];
    back_sum  = SW'(head_r) + SW'(count_r) - SW'(1);
    if (back_sum >= SW'(DEPTH)) begin
      back_sum = back_sum - SW'(DEPTH);
    end
    back_addr = back_sum[AW-1:0];
  end

  // command decode
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    wr_en     = 1'b0;
    wr_addr   = tail_addr;
    if (in_acc) begin
      ovf_nxt = 1'b0;
      case (in_cmd)
        bd_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            head_nxt  = head_dec;
            count_nxt = count_r + CW'(1);
            wr_en     = 1'b1;
            wr_addr   = head_dec;
          end
        end
        bd_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
            wr_en     = 1'b1;
            wr_addr   = tail_addr;
          end
        end
        bd_pkg::CMD_POP_FRONT: begin
          if (!empty) begin
            head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
            count_nxt = count_r - CW'(1);
          end
        end
        bd_pkg::CMD_POP_BACK: begin
          if (!empty) begin
            count_nxt = count_r - CW'(1);
          end
        end
        bd_pkg::CMD_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bd_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = bd_pkg::ST_READ;
        end
      end
      bd_pkg::ST_READ: begin
        state_nxt = bd_pkg::ST_LOAD;
      end
      bd_pkg::ST_LOAD: begin
        if (load) begin
          state_nxt = bd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bd_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    case (state_r)
      bd_pkg::ST_IDLE: in_stall = 1'b0;
      default:         in_stall = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bd_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    rd_front_r <= mem[head_r];
    rd_back_r  <= mem[back_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      front_r    <= empty ? '0 : rd_front_r;
      back_r     <= empty ? '0 : rd_back_r;
      total_r    <= count_r;
      is_empty_r <= empty;
      is_full_r  <= full;
      overflow_r <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_front_value   = front_r;
  assign out_back_value    = back_r;
  assign out_element_total = total_r;
  assign out_is_empty      = is_empty_r;
  assign out_is_full       = is_full_r;
  assign out_overflow      = overflow_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count beyond depth");

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == bd_pkg::ST_READ)
    else $error("accepted request did not start a read");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_front_value == '0 && out_back_value == '0)
    else $error("empty result carries data");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_is_full)
    else $error("overflow on a queue that is not full");

endmodule
